### src/split_l1_cache_tag_controller_unit_defines.svh
// assertion macros for the cache tag controller sequencer
`ifndef SPLIT_L1_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`define SPLIT_L1_CACHE_TAG_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SLCTC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slctc assertion failed");
`define SLCTC_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("slctc forbidden condition");
`else
`define SLCTC_ASSERT(label, clk, rst, prop)
`define SLCTC_NEVER(label, clk, rst, expr)
`endif
`endif

### src/slctc_pkg.sv
// shared codes and control types for the split l1 tag controller
`timescale 1ns / 1ps
`default_nettype none
package slctc_pkg;
  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_FETCH = 3'd2;
  localparam logic [2:0] ACT_INVAL = 3'd3;
  localparam logic [2:0] ACT_SNOOP = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_RFO   = 3'd2;
  localparam logic [2:0] OP_WT    = 3'd3;
  localparam logic [2:0] OP_WB    = 3'd4;
  localparam logic [2:0] OP_SNOOP = 3'd5;

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  typedef struct packed {
    logic load;
    logic lookup;
    logic sweep;
    logic advance;
  } ctl_t;

  typedef struct packed {
    logic clear_req;
    logic final_item;
  } stat_t;
endpackage
`default_nettype wire

### src/split_l1_cache_tag_controller_unit.sv
// Split L1 tag controller: 4-way I/S/E/M data cache and 2-way instruction cache.
// Requests enter on in_valid/in_ready with action and address. Each request
// produces zero to three L2 message items (only when report_l2 is set) and then
// one status item with last high, on out_valid/out_ready.
// Timing: the set row is read in the accept cycle, looked up and written back
// in the next cycle, and the first result is offered the cycle after that.
// A clear request sweeps max(DC_SETS, IC_SETS) rows, one per cycle, before
// its status item is offered.
// After reset the same sweep of max(DC_SETS, IC_SETS) rows runs with
// in_ready low; cfg_write_en writes report_l2 at any time.
// A stalled receiver holds the current result item; no new request is taken
// until the last item of the current one is delivered.
`timescale 1ns / 1ps
`default_nettype none
module split_l1_cache_tag_controller_unit import slctc_pkg::*; #(
  parameter int DC_WAYS    = 4,
  parameter int IC_WAYS    = 2,
  parameter int DC_SETS    = 16384,
  parameter int IC_SETS    = 16384,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       l2_op,
  output logic [31:0]      l2_address,
  output logic             hit,
  output logic             last
);
  localparam int SWEEP_LEN = (DC_SETS > IC_SETS) ? DC_SETS : IC_SETS;
  localparam int SW = $clog2(SWEEP_LEN);

  ctl_t          ctl;
  stat_t         stat;
  logic [SW-1:0] sweep_addr;

  slctc_ctrl #(.SWEEP_LEN(SWEEP_LEN)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctl        (ctl),
    .stat       (stat),
    .sweep_addr (sweep_addr)
  );

  slctc_dp #(
    .DC_WAYS    (DC_WAYS),
    .IC_WAYS    (IC_WAYS),
    .DC_SETS    (DC_SETS),
    .IC_SETS    (IC_SETS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SWEEP_LEN  (SWEEP_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .action         (action),
    .address        (address),
    .ctl            (ctl),
    .sweep_addr     (sweep_addr),
    .stat           (stat),
    .l2_op          (l2_op),
    .l2_address     (l2_address),
    .hit            (hit),
    .last           (last)
  );
endmodule
`default_nettype wire

### src/slctc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module slctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/slctc_ctrl.sv
// request sequencer: clearing sweep, lookup and result delivery
`timescale 1ns / 1ps
`default_nettype none
`include "split_l1_cache_tag_controller_unit_defines.svh"
module slctc_ctrl import slctc_pkg::*; #(
  parameter int SWEEP_LEN = 16384,
  localparam int SW = $clog2(SWEEP_LEN)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ctl_t               ctl,
  input  wire stat_t         stat,
  output logic [SW-1:0]      sweep_addr
);
  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_LOOKUP, S_SEND} state_t;

  state_t        state;
  logic [SW-1:0] cnt;
  logic          boot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      cnt   <= '0;
      boot  <= 1'b1;
    end else begin
      unique case (state)
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == SW'(SWEEP_LEN - 1)) begin
            cnt   <= '0;
            boot  <= 1'b0;
            state <= boot ? S_IDLE : S_SEND;
          end
        end
        S_IDLE: begin
          if (in_valid) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= stat.clear_req ? S_SWEEP : S_SEND;
        end
        S_SEND: begin
          if (out_ready && stat.final_item) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_SEND);
  assign ctl.load    = in_valid && in_ready;
  assign ctl.lookup  = (state == S_LOOKUP);
  assign ctl.sweep   = (state == S_SWEEP);
  assign ctl.advance = out_valid && out_ready;
  assign sweep_addr  = cnt;

  `SLCTC_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `SLCTC_ASSERT(a_load_lookup, clk, rst, ctl.load |=> ctl.lookup)
  `SLCTC_ASSERT(a_sweep_blocks, clk, rst, ctl.sweep |-> !in_ready && !out_valid)
endmodule
`default_nettype wire

### src/slctc_dp.sv
// tag/state datapath: set rams, hit and victim logic, result buffer
`timescale 1ns / 1ps
`default_nettype none
module slctc_dp import slctc_pkg::*; #(
  parameter int DC_WAYS    = 4,
  parameter int IC_WAYS    = 2,
  parameter int DC_SETS    = 16384,
  parameter int IC_SETS    = 16384,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_WIDTH = 32,
  parameter int SWEEP_LEN  = 16384,
  localparam int SW   = $clog2(SWEEP_LEN),
  localparam int EA   = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32,
  localparam int OB   = $clog2(LINE_BYTES),
  localparam int DSB  = $clog2(DC_SETS),
  localparam int ISB  = $clog2(IC_SETS),
  localparam int DTW  = EA - OB - DSB,
  localparam int ITW  = EA - OB - ISB,
  localparam int DRW  = $clog2(DC_WAYS + 1),
  localparam int IRW  = $clog2(IC_WAYS + 1),
  localparam int DWI  = $clog2(DC_WAYS),
  localparam int IWI  = (IC_WAYS > 1) ? $clog2(IC_WAYS) : 1,
  localparam int DROW = DC_WAYS * (DTW + 2 + DRW + 1),
  localparam int IROW = IC_WAYS * (ITW + 1 + IRW)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write_en,
  input  wire logic          cfg_write_data,
  input  wire logic [2:0]    action,
  input  wire logic [31:0]   address,
  input  wire ctl_t          ctl,
  input  wire logic [SW-1:0] sweep_addr,
  output stat_t              stat,
  output logic [2:0]         l2_op,
  output logic [31:0]        l2_address,
  output logic               hit,
  output logic               last
);
  logic          report_l2;
  logic [2:0]    act_q;
  logic [EA-1:0] addr_q;
  logic [2:0]    msg_op   [4];
  logic [31:0]   msg_addr [4];
  logic [1:0]    msg_cnt;
  logic [1:0]    send_idx;
  logic          hit_q;

  logic [DSB-1:0] set_d;
  logic [DTW-1:0] tag_d;
  logic [ISB-1:0] set_i;
  logic [ITW-1:0] tag_i;
  logic [31:0]    line32;

  logic [DROW-1:0] d_rdata, d_wdata;
  logic [IROW-1:0] i_rdata, i_wdata;
  logic            d_we, i_we;

  logic [DC_WAYS-1:0][DTW-1:0] d_tg, n_tg;
  logic [DC_WAYS-1:0][1:0]     d_st, n_st;
  logic [DC_WAYS-1:0][DRW-1:0] d_rk, n_rk;
  logic [DC_WAYS-1:0]          d_wo, n_wo;
  logic [IC_WAYS-1:0][ITW-1:0] i_tg, ni_tg;
  logic [IC_WAYS-1:0]          i_vl, ni_vl;
  logic [IC_WAYS-1:0][IRW-1:0] i_rk, ni_rk;

  logic [2:0]  m_op   [4];
  logic [31:0] m_addr [4];
  logic [1:0]  m_cnt;
  logic        m_hit;
  logic        d_upd, i_upd;
  logic        f_wb, f_rd, f_rfo, f_wt, f_snp;
  logic [31:0] wb_addr;

  function automatic logic [DC_WAYS-1:0][DRW-1:0] d_touch(
      input logic [DC_WAYS-1:0][DRW-1:0] rk, input logic [DWI-1:0] w);
    logic [DC_WAYS-1:0][DRW-1:0] res;
    logic [DRW-1:0] r;
    res = rk;
    r   = rk[w];
    for (int i = 0; i < DC_WAYS; i++) begin
      if (rk[i] != '0 && (r == '0 || rk[i] < r)) res[i] = rk[i] + 1'b1;
    end
    res[w] = DRW'(1);
    return res;
  endfunction

  function automatic logic [IC_WAYS-1:0][IRW-1:0] i_touch(
      input logic [IC_WAYS-1:0][IRW-1:0] rk, input logic [IWI-1:0] w);
    logic [IC_WAYS-1:0][IRW-1:0] res;
    logic [IRW-1:0] r;
    res = rk;
    r   = rk[w];
    for (int i = 0; i < IC_WAYS; i++) begin
      if (rk[i] != '0 && (r == '0 || rk[i] < r)) res[i] = rk[i] + 1'b1;
    end
    res[w] = IRW'(1);
    return res;
  endfunction

  assign set_d  = addr_q[OB +: DSB];
  assign tag_d  = addr_q[OB + DSB +: DTW];
  assign set_i  = addr_q[OB +: ISB];
  assign tag_i  = addr_q[OB + ISB +: ITW];
  assign line32 = 32'({addr_q[EA-1:OB], {OB{1'b0}}});

  assign {d_tg, d_st, d_rk, d_wo} = d_rdata;
  assign {i_tg, i_vl, i_rk}       = i_rdata;

  always_comb begin
    logic           dh, dfree, dlru, ih, ifree, ilru, inv;
    logic [DWI-1:0] dw, dv, iv_w;
    logic [IWI-1:0] iw, iv;
    dh = 1'b0; dfree = 1'b0; dlru = 1'b0; ih = 1'b0; ifree = 1'b0; ilru = 1'b0;
    inv = 1'b0;
    dw = '0; dv = '0; iv_w = '0; iw = '0; iv = '0;
    n_tg = d_tg; n_st = d_st; n_rk = d_rk; n_wo = d_wo;
    ni_tg = i_tg; ni_vl = i_vl; ni_rk = i_rk;
    f_wb = 1'b0; f_rd = 1'b0; f_rfo = 1'b0; f_wt = 1'b0; f_snp = 1'b0;
    m_hit = 1'b0; d_upd = 1'b0; i_upd = 1'b0;

    for (int i = 0; i < DC_WAYS; i++) begin
      if (!dh && d_st[i] != ST_I && d_tg[i] == tag_d) begin
        dh = 1'b1;
        dw = DWI'(i);
      end
      if (!dfree && d_st[i] == ST_I) begin
        dfree = 1'b1;
        dv    = DWI'(i);
      end
      if (!inv && (d_st[i] == ST_E || d_st[i] == ST_S) && d_tg[i] == tag_d) begin
        inv  = 1'b1;
        iv_w = DWI'(i);
      end
    end
    // no empty way: take the least recent way, or way 0 if none ranks last
    if (!dfree) begin
      for (int i = 0; i < DC_WAYS; i++) begin
        if (!dlru && d_rk[i] == DRW'(DC_WAYS)) begin
          dlru = 1'b1;
          dv   = DWI'(i);
        end
      end
    end
    for (int i = 0; i < IC_WAYS; i++) begin
      if (!ih && i_vl[i] && i_tg[i] == tag_i) begin
        ih = 1'b1;
        iw = IWI'(i);
      end
      if (!ifree && !i_vl[i]) begin
        ifree = 1'b1;
        iv    = IWI'(i);
      end
    end
    if (!ifree) begin
      for (int i = 0; i < IC_WAYS; i++) begin
        if (!ilru && i_rk[i] == IRW'(IC_WAYS)) begin
          ilru = 1'b1;
          iv   = IWI'(i);
        end
      end
    end
    wb_addr = 32'({d_tg[dv], set_d, {OB{1'b0}}});

    unique case (act_q) inside
      ACT_READ, ACT_WRITE: begin
        m_hit = dh;
        d_upd = 1'b1;
        if (dh) begin
          if (act_q == ACT_WRITE) begin
            if (d_wo[dw]) begin
              n_st[dw] = ST_M;
            end else begin
              f_wt     = 1'b1;
              n_wo[dw] = 1'b1;
              n_st[dw] = ST_E;
            end
          end
          n_rk = d_touch(d_rk, dw);
        end else begin
          f_wb     = (d_st[dv] == ST_M);
          n_tg[dv] = tag_d;
          if (act_q == ACT_READ) begin
            f_rd     = 1'b1;
            n_st[dv] = ST_S;
            n_wo[dv] = 1'b0;
          end else begin
            f_rfo    = 1'b1;
            f_wt     = 1'b1;
            n_st[dv] = ST_E;
            n_wo[dv] = 1'b1;
          end
          n_rk = d_touch(d_rk, dv);
        end
      end
      ACT_INVAL: begin
        m_hit = dh;
        d_upd = 1'b1;
        if (inv) begin
          n_st[iv_w] = ST_I;
          for (int j = 0; j < DC_WAYS; j++) begin
            if (DWI'(j) != iv_w && d_rk[j] > d_rk[iv_w]) n_rk[j] = d_rk[j] - 1'b1;
          end
          n_rk[iv_w] = '0;
        end
      end
      ACT_SNOOP: begin
        m_hit = dh;
        d_upd = 1'b1;
        if (dh) begin
          f_snp    = (d_st[dw] == ST_M);
          n_st[dw] = ST_S;
        end
      end
      ACT_FETCH: begin
        m_hit = ih;
        i_upd = 1'b1;
        if (ih) begin
          ni_rk = i_touch(i_rk, iw);
        end else begin
          ni_vl[iv] = 1'b1;
          ni_tg[iv] = tag_i;
          f_rd      = 1'b1;
          ni_rk     = i_touch(i_rk, iv);
        end
      end
      default: ;
    endcase
  end

  // bus messages in issue order, then the status slot stays zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m_op[k]   = OP_NONE;
      m_addr[k] = '0;
    end
    m_cnt = '0;
    if (report_l2) begin
      if (f_wb) begin
        m_op[m_cnt] = OP_WB;  m_addr[m_cnt] = wb_addr; m_cnt = m_cnt + 1'b1;
      end
      if (f_rd) begin
        m_op[m_cnt] = OP_READ; m_addr[m_cnt] = line32; m_cnt = m_cnt + 1'b1;
      end
      if (f_rfo) begin
        m_op[m_cnt] = OP_RFO; m_addr[m_cnt] = line32; m_cnt = m_cnt + 1'b1;
      end
      if (f_wt) begin
        m_op[m_cnt] = OP_WT;  m_addr[m_cnt] = line32; m_cnt = m_cnt + 1'b1;
      end
      if (f_snp) begin
        m_op[m_cnt] = OP_SNOOP; m_addr[m_cnt] = line32; m_cnt = m_cnt + 1'b1;
      end
    end
  end

  assign d_we    = ctl.sweep || (ctl.lookup && d_upd);
  assign i_we    = ctl.sweep || (ctl.lookup && i_upd);
  assign d_wdata = ctl.sweep ? '0 : {n_tg, n_st, n_rk, n_wo};
  assign i_wdata = ctl.sweep ? '0 : {ni_tg, ni_vl, ni_rk};

  slctc_ram #(.WIDTH(DROW), .DEPTH(DC_SETS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (ctl.sweep ? sweep_addr[DSB-1:0] : set_d),
    .wdata (d_wdata),
    .raddr (address[OB +: DSB]),
    .rdata (d_rdata)
  );

  slctc_ram #(.WIDTH(IROW), .DEPTH(IC_SETS)) u_ins_ram (
    .clk   (clk),
    .we    (i_we),
    .waddr (ctl.sweep ? sweep_addr[ISB-1:0] : set_i),
    .wdata (i_wdata),
    .raddr (address[OB +: ISB]),
    .rdata (i_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_l2 <= 1'b0;
      send_idx  <= '0;
    end else begin
      if (cfg_write_en) report_l2 <= cfg_write_data;
      if (ctl.load) begin
        send_idx <= '0;
      end else if (ctl.advance) begin
        send_idx <= send_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act_q  <= action;
      addr_q <= address[EA-1:0];
    end
    if (ctl.lookup) begin
      msg_op   <= m_op;
      msg_addr <= m_addr;
      msg_cnt  <= m_cnt;
      hit_q    <= m_hit;
    end
  end

  assign l2_op           = msg_op[send_idx];
  assign l2_address      = msg_addr[send_idx];
  assign hit             = hit_q;
  assign last            = (send_idx == msg_cnt);
  assign stat.clear_req  = (act_q == ACT_CLEAR);
  assign stat.final_item = last;
endmodule
`default_nettype wire

### test/split_l1_cache_tag_controller_unit_checker.sv
// request tracker, line state predictor and result comparison for the tag controller
`timescale 1ns / 1ps
`default_nettype none
module split_l1_cache_tag_controller_unit_checker import slctc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] address,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  l2_op,
  input  wire logic [31:0] l2_address,
  input  wire logic        hit,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);
  localparam int DWAYS = 4;
  localparam int IWAYS = 2;
  localparam int NSETS = 16384;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic        hit;
    logic        last;
  } bus_item_t;

  logic [11:0] dtag  [NSETS][DWAYS];
  logic [1:0]  dstate[NSETS][DWAYS];
  logic [2:0]  drank [NSETS][DWAYS];
  logic        dwonce[NSETS][DWAYS];
  logic [11:0] itag  [NSETS][IWAYS];
  logic        ivalid[NSETS][IWAYS];
  logic [1:0]  irank [NSETS][IWAYS];
  logic        report_l2;
  logic        cur_hit;
  bus_item_t   expected_q[$];

  task automatic wipe_lines();
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < DWAYS; w++) begin
        dstate[s][w] = ST_I;
        drank[s][w] = '0;
        dwonce[s][w] = 1'b0;
      end
      for (int w = 0; w < IWAYS; w++) begin
        ivalid[s][w] = 1'b0;
        irank[s][w] = '0;
      end
    end
  endtask

  task automatic queue_msg(logic [2:0] op, logic [31:0] a);
    if (report_l2) expected_q.push_back('{op, a, cur_hit, 1'b0});
  endtask

  task automatic touch_data(int s, int w);
    logic [2:0] r;
    r = drank[s][w];
    for (int i = 0; i < DWAYS; i++)
      if (drank[s][i] != 0 && (r == 0 || drank[s][i] < r)) drank[s][i]++;
    drank[s][w] = 1;
  endtask

  task automatic touch_ins(int s, int w);
    logic [1:0] r;
    r = irank[s][w];
    for (int i = 0; i < IWAYS; i++)
      if (irank[s][i] != 0 && (r == 0 || irank[s][i] < r)) irank[s][i]++;
    irank[s][w] = 1;
  endtask

  task automatic predict_request(logic [2:0] act, logic [31:0] a);
    int s, w, v;
    logic [11:0] tg;
    logic [31:0] line;
    s = a[19:6];
    tg = a[31:20];
    line = {a[31:6], 6'b0};
    cur_hit = 1'b0;
    w = -1;
    v = -1;
    if (act == ACT_READ || act == ACT_WRITE || act == ACT_INVAL || act == ACT_SNOOP) begin
      for (int i = 0; i < DWAYS; i++)
        if (w < 0 && dstate[s][i] != ST_I && dtag[s][i] == tg) w = i;
      cur_hit = (w >= 0);
      if (act == ACT_READ || act == ACT_WRITE) begin
        if (w >= 0) begin
          if (act == ACT_WRITE) begin
            if (dwonce[s][w]) begin
              dstate[s][w] = ST_M;
            end else begin
              queue_msg(OP_WT, line);
              dwonce[s][w] = 1'b1;
              dstate[s][w] = ST_E;
            end
          end
          touch_data(s, w);
        end else begin
          for (int i = 0; i < DWAYS; i++)
            if (v < 0 && dstate[s][i] == ST_I) v = i;
          for (int i = 0; i < DWAYS; i++)
            if (v < 0 && drank[s][i] == DWAYS) v = i;
          if (v < 0) v = 0;
          // dirty victim goes back first
          if (dstate[s][v] == ST_M) queue_msg(OP_WB, {dtag[s][v], s[13:0], 6'b0});
          dtag[s][v] = tg;
          dwonce[s][v] = 1'b0;
          if (act == ACT_READ) begin
            queue_msg(OP_READ, line);
            dstate[s][v] = ST_S;
          end else begin
            queue_msg(OP_RFO, line);
            queue_msg(OP_WT, line);
            dstate[s][v] = ST_E;
            dwonce[s][v] = 1'b1;
          end
          touch_data(s, v);
        end
      end else if (act == ACT_INVAL) begin
        for (int i = 0; i < DWAYS; i++) begin
          if (v < 0 && (dstate[s][i] == ST_E || dstate[s][i] == ST_S) && dtag[s][i] == tg) begin
            v = i;
            dstate[s][i] = ST_I;
            for (int j = 0; j < DWAYS; j++)
              if (j != i && drank[s][j] > drank[s][i]) drank[s][j]--;
            drank[s][i] = 0;
          end
        end
      end else if (w >= 0) begin
        if (dstate[s][w] == ST_M) queue_msg(OP_SNOOP, line);
        dstate[s][w] = ST_S;
      end
    end else if (act == ACT_FETCH) begin
      for (int i = 0; i < IWAYS; i++)
        if (w < 0 && ivalid[s][i] && itag[s][i] == tg) w = i;
      cur_hit = (w >= 0);
      if (w >= 0) begin
        touch_ins(s, w);
      end else begin
        for (int i = 0; i < IWAYS; i++)
          if (v < 0 && !ivalid[s][i]) v = i;
        for (int i = 0; i < IWAYS; i++)
          if (v < 0 && irank[s][i] == IWAYS) v = i;
        if (v < 0) v = 0;
        ivalid[s][v] = 1'b1;
        itag[s][v] = tg;
        queue_msg(OP_READ, line);
        touch_ins(s, v);
      end
    end else if (act == ACT_CLEAR) begin
      wipe_lines();
    end
    expected_q.push_back('{OP_NONE, 32'd0, cur_hit, 1'b1});
  endtask

  always @(posedge clk) begin
    bus_item_t exp_item;
    if (rst) begin
      fail_count = 0;
      pending = 0;
      report_l2 <= 1'b0;
      wipe_lines();
    end else begin
      if (cfg_write_en) report_l2 <= cfg_write_data;
      if (in_valid && in_ready) predict_request(action, address);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item op=%0d addr=%h hit=%0b last=%0b",
                   $time, l2_op, l2_address, hit, last);
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          if (l2_op !== exp_item.op || l2_address !== exp_item.addr ||
              hit !== exp_item.hit || last !== exp_item.last) begin
            $display("%0t: mismatch expected op=%0d addr=%h hit=%0b last=%0b",
                     $time, exp_item.op, exp_item.addr, exp_item.hit, exp_item.last);
            $display("%0t:          actual   op=%0d addr=%h hit=%0b last=%0b",
                     $time, l2_op, l2_address, hit, last);
            fail_count++;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule
`default_nettype wire

### test/split_l1_cache_tag_controller_unit_tb.sv
// stimulus, flow control and verdict for the split l1 tag controller
`timescale 1ns / 1ps
`default_nettype none
module split_l1_cache_tag_controller_unit_tb;
  import slctc_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = ACT_READ;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  l2_op;
  logic [31:0] l2_address;
  logic        hit;
  logic        last;
  int          fail_count;
  int          pending;
  bit          idle_en = 1'b0;
  bit          long_hold = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  logic [13:0] set_pool[6];
  logic [11:0] tag_pool[6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  split_l1_cache_tag_controller_unit uut (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .l2_op(l2_op),
    .l2_address(l2_address), .hit(hit), .last(last)
  );

  split_l1_cache_tag_controller_unit_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .address(address),
    .out_valid(out_valid), .out_ready(out_ready), .l2_op(l2_op),
    .l2_address(l2_address), .hit(hit), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // hold one request on the input until it is taken, then maybe leave a gap
  task automatic send_request(logic [2:0] act, logic [31:0] a);
    in_valid <= 1'b1;
    action <= act;
    address <= a;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_report(logic v);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pool_address(int t, int s);
    return {tag_pool[t], set_pool[s], 6'($urandom)};
  endfunction

  task automatic send_random(int n);
    int pick;
    logic [2:0] act;
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) act = ACT_READ;
      else if (pick < 55) act = ACT_WRITE;
      else if (pick < 74) act = ACT_FETCH;
      else if (pick < 84) act = ACT_SNOOP;
      else if (pick < 95) act = ACT_INVAL;
      else if (pick < 98) act = 3'($urandom_range(6, 7));
      else act = ACT_CLEAR;
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else a = pool_address($urandom_range(0, 5), $urandom_range(0, 5));
      send_request(act, a);
    end
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver side: random short stalls, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [31:0] base;
    set_pool[0] = '0;
    set_pool[1] = '1;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) begin
      set_pool[i] = 14'($urandom);
      tag_pool[i] = 12'($urandom);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_report(1'b1);

    base = 32'h1234_5678;
    send_request(ACT_READ, base);
    send_request(ACT_READ, base);
    send_request(ACT_WRITE, base);
    send_request(ACT_WRITE, base);
    send_request(ACT_SNOOP, base);
    send_request(ACT_WRITE, base);
    send_request(ACT_INVAL, base);
    // fill the set with other tags so the dirty line gets evicted
    for (int i = 1; i <= 4; i++) send_request(ACT_READ, base + (i << 20));
    send_request(ACT_WRITE, base + (5 << 20));
    send_request(ACT_INVAL, base + (5 << 20));
    send_request(ACT_SNOOP, base + (2 << 20));
    send_request(ACT_FETCH, 32'h0);
    send_request(ACT_FETCH, 32'h0);
    send_request(ACT_FETCH, 32'h0010_0000);
    send_request(ACT_FETCH, 32'h0020_0000);
    send_request(ACT_WRITE, 32'hFFFF_FFFF);
    send_request(3'd6, 32'hFFFF_FFFF);
    send_request(3'd7, 32'h0);
    send_request(ACT_CLEAR, 32'h0);
    send_request(ACT_READ, base);

    idle_en = 1'b1;
    long_hold = 1'b1;
    send_random(120);
    write_report(1'b0);
    send_random(120);
    write_report(1'b1);
    send_random(60);
    idle_en = 1'b0;
    send_random(60);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+src
src/slctc_pkg.sv
src/slctc_ram.sv
src/slctc_ctrl.sv
src/slctc_dp.sv
src/split_l1_cache_tag_controller_unit.sv
test/split_l1_cache_tag_controller_unit_checker.sv
test/split_l1_cache_tag_controller_unit_tb.sv
